// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros shared by the script tokenizer RTL.
// Each macro expects i_clk and i_rst_n (active low) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/stk_pkg.sv -----
// Shared types, character codes and classifier functions for the script tokenizer.
// No dependencies; used by stk_scan, stk_res_queue and script_tokenizer_core.
`default_nettype none

package stk_pkg;

    // Scanner modes; codes that are not listed act as between tokens.
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_SLASH   = 3'd2,
        MODE_WORD    = 3'd3,
        MODE_QUOTE   = 3'd4
    } t_mode;

    // Token kinds as they appear on the output.
    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_STRING = 2'd1,
        KIND_DELIM  = 2'd2
    } t_kind;

    // Character codes the scanner reacts to.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Output length field width, results per byte and result queue sizing.
    localparam int LEN_W       = 6;
    localparam int RES_MAX     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One result item.
    typedef struct packed {
        logic [7:0]       token_byte;
        logic             byte_valid;
        logic             token_last;
        t_kind            token_kind;
        logic [LEN_W-1:0] token_length;
        logic             truncated;
    } t_result;

    // All results caused by one input byte, slot 0 first.
    typedef struct packed {
        t_result [RES_MAX-1:0] res;
        logic [1:0]            cnt;
    } t_res_group;

    // Control bytes, space and the upper half (negative as signed char).
    function automatic logic is_space(input logic [7:0] b);
        return (b <= CH_SPACE) || b[7];
    endfunction

    // One-character tokens.
    function automatic logic is_delim(input logic [7:0] b);
        return b inside {CH_LBRACE, CH_RBRACE, CH_RPAREN, CH_LPAREN, CH_APOS, CH_COLON};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stk_scan.sv -----
// Combinational scanner step: next mode, count and overflow flag plus up to
// three results for one text byte. Depends on stk_pkg.
`default_nettype none

module stk_scan #(
    parameter int MAX_TOKEN = 64,
    localparam int CntW = $clog2(MAX_TOKEN)
) (
    input  wire logic [7:0]          i_byte,
    input  wire stk_pkg::t_mode      i_mode,
    input  wire logic [CntW-1:0]     i_kept,
    input  wire logic                i_ovf,
    output stk_pkg::t_mode           o_next_mode,
    output logic [CntW-1:0]          o_next_kept,
    output logic                     o_next_ovf,
    output stk_pkg::t_res_group      o_group
);

    localparam logic [CntW-1:0] KeepMax = CntW'(MAX_TOKEN - 1);
    localparam logic [CntW-1:0] KeptOne = CntW'(1);

    // Build one result; the length is the kept count masked to the field width.
    function automatic stk_pkg::t_result mk(input logic [7:0] b, input logic valid,
                                            input logic last, input stk_pkg::t_kind kind,
                                            input logic [CntW-1:0] kept, input logic trunc);
        stk_pkg::t_result              r;
        logic [CntW+stk_pkg::LEN_W-1:0] ext;
        ext            = (CntW + stk_pkg::LEN_W)'(kept);
        r.token_byte   = b;
        r.byte_valid   = valid;
        r.token_last   = last;
        r.token_kind   = kind;
        r.token_length = ext[stk_pkg::LEN_W-1:0];
        r.truncated    = trunc;
        return r;
    endfunction

    logic                      held_slash;
    logic [CntW-1:0]           base_kept;
    logic                      base_ovf;
    stk_pkg::t_result [1:0]    w_res;
    logic [1:0]                w_cnt;
    stk_pkg::t_mode            w_mode;
    logic [CntW-1:0]           w_kept;
    logic                      w_ovf;

    // A held slash released by a non-slash byte becomes the first word character.
    assign held_slash = (i_mode == stk_pkg::MODE_SLASH) && (i_byte != stk_pkg::CH_SLASH);
    assign base_kept  = held_slash ? KeptOne : i_kept;
    assign base_ovf   = held_slash ? 1'b0 : i_ovf;

    // Handling of a byte inside a word.
    always_comb begin
        w_res  = '0;
        w_cnt  = 2'd0;
        w_mode = stk_pkg::MODE_WORD;
        w_kept = base_kept;
        w_ovf  = base_ovf;
        if (stk_pkg::is_delim(i_byte)) begin
            // Close the word, then emit the delimiter as its own token.
            w_res[0] = mk(stk_pkg::CH_NUL, 1'b0, 1'b1, stk_pkg::KIND_WORD, base_kept, base_ovf);
            w_res[1] = mk(i_byte, 1'b1, 1'b1, stk_pkg::KIND_DELIM, KeptOne, 1'b0);
            w_cnt    = 2'd2;
            w_mode   = stk_pkg::MODE_IDLE;
            w_kept   = '0;
            w_ovf    = 1'b0;
        end else if (stk_pkg::is_space(i_byte)) begin
            w_res[0] = mk(stk_pkg::CH_NUL, 1'b0, 1'b1, stk_pkg::KIND_WORD, base_kept, base_ovf);
            w_cnt    = 2'd1;
            w_mode   = stk_pkg::MODE_IDLE;
            w_kept   = '0;
            w_ovf    = 1'b0;
        end else if (base_kept < KeepMax) begin
            w_kept   = base_kept + KeptOne;
            w_res[0] = mk(i_byte, 1'b1, 1'b0, stk_pkg::KIND_WORD, w_kept, 1'b0);
            w_cnt    = 2'd1;
        end else begin
            w_ovf = 1'b1;
        end
    end

    // Mode dispatch.
    always_comb begin
        o_next_mode = i_mode;
        o_next_kept = i_kept;
        o_next_ovf  = i_ovf;
        o_group     = '0;
        case (i_mode)
            stk_pkg::MODE_COMMENT: begin
                if ((i_byte == stk_pkg::CH_NUL) || (i_byte == stk_pkg::CH_NL)) begin
                    o_next_mode = stk_pkg::MODE_IDLE;
                end
            end
            stk_pkg::MODE_SLASH: begin
                if (held_slash) begin
                    o_group.res = {w_res[1], w_res[0],
                                   mk(stk_pkg::CH_SLASH, 1'b1, 1'b0, stk_pkg::KIND_WORD,
                                      KeptOne, 1'b0)};
                    o_group.cnt = w_cnt + 2'd1;
                    o_next_mode = w_mode;
                    o_next_kept = w_kept;
                    o_next_ovf  = w_ovf;
                end else begin
                    o_next_mode = stk_pkg::MODE_COMMENT;
                end
            end
            stk_pkg::MODE_WORD: begin
                o_group.res = {stk_pkg::t_result'('0), w_res[1], w_res[0]};
                o_group.cnt = w_cnt;
                o_next_mode = w_mode;
                o_next_kept = w_kept;
                o_next_ovf  = w_ovf;
            end
            stk_pkg::MODE_QUOTE: begin
                if ((i_byte == stk_pkg::CH_QUOTE) || (i_byte == stk_pkg::CH_NUL)) begin
                    o_group.res[0] = mk(stk_pkg::CH_NUL, 1'b0, 1'b1, stk_pkg::KIND_STRING,
                                        i_kept, i_ovf);
                    o_group.cnt    = 2'd1;
                    o_next_mode    = stk_pkg::MODE_IDLE;
                    o_next_kept    = '0;
                    o_next_ovf     = 1'b0;
                end else if (i_kept < KeepMax) begin
                    o_next_kept    = i_kept + KeptOne;
                    o_group.res[0] = mk(i_byte, 1'b1, 1'b0, stk_pkg::KIND_STRING,
                                        o_next_kept, 1'b0);
                    o_group.cnt    = 2'd1;
                end else begin
                    o_next_ovf = 1'b1;
                end
            end
            default: begin
                // Between tokens: whitespace is skipped, anything else opens a token.
                o_next_mode = stk_pkg::MODE_IDLE;
                if (!stk_pkg::is_space(i_byte)) begin
                    o_next_kept = '0;
                    o_next_ovf  = 1'b0;
                    if (i_byte == stk_pkg::CH_SLASH) begin
                        o_next_mode = stk_pkg::MODE_SLASH;
                    end else if (i_byte == stk_pkg::CH_QUOTE) begin
                        o_next_mode = stk_pkg::MODE_QUOTE;
                    end else if (stk_pkg::is_delim(i_byte)) begin
                        o_group.res[0] = mk(i_byte, 1'b1, 1'b1, stk_pkg::KIND_DELIM,
                                            KeptOne, 1'b0);
                        o_group.cnt    = 2'd1;
                    end else begin
                        o_next_mode    = stk_pkg::MODE_WORD;
                        o_next_kept    = KeptOne;
                        o_group.res[0] = mk(i_byte, 1'b1, 1'b0, stk_pkg::KIND_WORD,
                                            KeptOne, 1'b0);
                        o_group.cnt    = 2'd1;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/stk_res_queue.sv -----
// Four-entry result queue: takes up to three results per cycle, gives one.
// Depends on stk_pkg.
`default_nettype none

module stk_res_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_en,
    input  wire stk_pkg::t_res_group i_wr,
    input  wire logic                i_rd,
    output stk_pkg::t_result         o_rd_data,
    output logic                     o_valid,
    output logic                     o_room
);

    stk_pkg::t_result                  r_mem [stk_pkg::QUEUE_DEPTH];
    logic [stk_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [stk_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [stk_pkg::QCNT_W-1:0]        r_count;
    logic [stk_pkg::QCNT_W-1:0]        n_count;
    logic [1:0]                        wr_cnt;
    logic                              rd_go;

    assign wr_cnt  = i_wr_en ? i_wr.cnt : 2'd0;
    assign rd_go   = i_rd && o_valid;
    assign n_count = r_count + stk_pkg::QCNT_W'(wr_cnt) - stk_pkg::QCNT_W'(rd_go);

    // Room for a full group of results is judged from the stored count only.
    assign o_valid   = (r_count != '0);
    assign o_room    = (r_count <= stk_pkg::QCNT_W'(stk_pkg::QUEUE_DEPTH - stk_pkg::RES_MAX));
    assign o_rd_data = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + stk_pkg::QPTR_W'(wr_cnt);
            r_rd_ptr <= r_rd_ptr + stk_pkg::QPTR_W'(rd_go);
            r_count  <= n_count;
        end
    end

    // Result storage, written in order from the write pointer.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < stk_pkg::RES_MAX; k++) begin
            if (2'(k) < wr_cnt) begin
                r_mem[r_wr_ptr + stk_pkg::QPTR_W'(k)] <= i_wr.res[k];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/script_tokenizer_core.sv -----
// Top level of the script tokenizer: scanner state, scanner step and result queue.
// Depends on stk_pkg, stk_scan, stk_res_queue and assert_macros.svh.
//
// The tokenizer takes script text one byte per request and streams out tokens one
// character per result, each token closed by a result with tlast set. Results are
// written into the four-entry result queue and shown from there. A new byte is
// taken every cycle, but only while the queue holds at most one result, and the
// queue drains one result per cycle while the output is ready. So a byte that gives
// two or three results (a word ended by a delimiter, or a held slash released)
// keeps the input waiting until the queue is down to one result again. Tokens keep at most
// MAX_TOKEN-1 characters; the rest are dropped and flagged on the closing result.
`default_nettype none

module script_tokenizer_core #(
    parameter int MAX_TOKEN = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream. tdata: text_byte[7:0].
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,
    // Output stream. tdata: token_byte[7:0], token_length[13:8], truncated[14], zero[15].
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    // tuser: byte_valid[0], token_kind[2:1].
    output logic [2:0]       o_m_axis_tuser
);

    localparam int CntW = $clog2(MAX_TOKEN);

    stk_pkg::t_mode       r_mode;
    stk_pkg::t_mode       n_mode;
    logic [CntW-1:0]      r_kept;
    logic [CntW-1:0]      n_kept;
    logic                 r_ovf;
    logic                 n_ovf;
    stk_pkg::t_res_group  scan_group;
    stk_pkg::t_result     out_res;
    logic                 accept;
    logic                 queue_room;

    assign accept          = i_s_axis_tvalid && queue_room;
    assign o_s_axis_tready = queue_room;

    // Scanner step for the byte on the input.
    stk_scan #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_scan (
        .i_byte      (i_s_axis_tdata),
        .i_mode      (r_mode),
        .i_kept      (r_kept),
        .i_ovf       (r_ovf),
        .o_next_mode (n_mode),
        .o_next_kept (n_kept),
        .o_next_ovf  (n_ovf),
        .o_group     (scan_group)
    );

    // Scanner state advances on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stk_pkg::MODE_IDLE;
            r_kept <= '0;
            r_ovf  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_kept <= n_kept;
            r_ovf  <= n_ovf;
        end
    end

    // Results wait here until the output side takes them.
    stk_res_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept),
        .i_wr      (scan_group),
        .i_rd      (i_m_axis_tready),
        .o_rd_data (out_res),
        .o_valid   (o_m_axis_tvalid),
        .o_room    (queue_room)
    );

    // Output packing.
    assign o_m_axis_tdata = {1'b0, out_res.truncated, out_res.token_length, out_res.token_byte};
    assign o_m_axis_tlast = out_res.token_last;
    assign o_m_axis_tuser = {out_res.token_kind, out_res.byte_valid};

    `include "assert_macros.svh"

    // The kept count never passes the token limit.
    `STK_ASSERT_SAME(a_kept_limit, 1'b1, r_kept <= CntW'(MAX_TOKEN - 1), "kept count over limit")
    // Between tokens no characters are counted.
    `STK_ASSERT_SAME(a_idle_clear, r_mode == stk_pkg::MODE_IDLE, r_kept == '0,
                     "kept count not cleared between tokens")
    // A byte that causes results makes the output valid in the next cycle.
    `STK_ASSERT_NEXT(a_result_shows, accept && (scan_group.cnt != 2'd0), o_m_axis_tvalid,
                     "result of accepted byte not shown")
    // A result without a character only ever closes a token.
    `STK_ASSERT_SAME(a_bare_end_last, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tlast,
                     "bare result is not a token end")

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for script_tokenizer_core: drives script text, predicts the tokens.
// Depends on stk_pkg for the result struct, token kinds, scanner modes and character codes.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKEN_LIMIT = 64;
    localparam int IDLE_LIMIT  = 5000;
    localparam int REPORT_MAX  = 10;
    localparam int ITEM_TARGET = 230;
    localparam int PAUSE_POINT = 195;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    // Predicted scanner state and the tokens still owed by the block.
    stk_pkg::t_mode   scan_state    = stk_pkg::MODE_IDLE;
    int unsigned      kept_chars    = 0;
    bit               chars_dropped = 1'b0;
    stk_pkg::t_result token_results_due[$];

    int mismatch_count = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;
    int bytes_sent     = 0;

    script_tokenizer_core #(
        .MAX_TOKEN(TOKEN_LIMIT)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast),
        .o_m_axis_tuser (m_tuser)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Character classes of the scanner.
    function automatic bit is_blank(input logic [7:0] c);
        return c[7] || (c < 8'd33);
    endfunction

    function automatic bit is_single_char(input logic [7:0] c);
        case (c)
            stk_pkg::CH_LBRACE, stk_pkg::CH_RBRACE, stk_pkg::CH_LPAREN,
            stk_pkg::CH_RPAREN, stk_pkg::CH_APOS, stk_pkg::CH_COLON: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_result(input logic [7:0] ch, input logic valid,
                                        input logic last, input stk_pkg::t_kind kind,
                                        input int unsigned len, input logic trunc);
        stk_pkg::t_result r;
        r.token_byte   = ch;
        r.byte_valid   = valid;
        r.token_last   = last;
        r.token_kind   = kind;
        r.token_length = len[stk_pkg::LEN_W-1:0];
        r.truncated    = trunc;
        token_results_due.push_back(r);
    endfunction

    // A character past the size limit is dropped and remembered for the closing result.
    function automatic void keep_token_char(input logic [7:0] ch, input stk_pkg::t_kind kind);
        if (kept_chars < TOKEN_LIMIT - 1) begin
            kept_chars++;
            push_result(ch, 1'b1, 1'b0, kind, kept_chars, 1'b0);
        end else begin
            chars_dropped = 1'b1;
        end
    endfunction

    function automatic void close_open_token(input stk_pkg::t_kind kind);
        push_result(8'h00, 1'b0, 1'b1, kind, kept_chars, chars_dropped);
        kept_chars    = 0;
        chars_dropped = 1'b0;
        scan_state    = stk_pkg::MODE_IDLE;
    endfunction

    function automatic void emit_single_char(input logic [7:0] ch);
        kept_chars    = 0;
        chars_dropped = 1'b0;
        scan_state    = stk_pkg::MODE_IDLE;
        push_result(ch, 1'b1, 1'b1, stk_pkg::KIND_DELIM, 1, 1'b0);
    endfunction

    // Inside a word: a delimiter closes the word and then stands as its own token.
    function automatic void word_char_step(input logic [7:0] ch);
        if (is_single_char(ch)) begin
            close_open_token(stk_pkg::KIND_WORD);
            emit_single_char(ch);
        end else if (is_blank(ch)) begin
            close_open_token(stk_pkg::KIND_WORD);
        end else begin
            keep_token_char(ch, stk_pkg::KIND_WORD);
        end
    endfunction

    // Advance the predicted scanner by one accepted byte.
    function automatic void predict_token_results(input logic [7:0] ch);
        case (scan_state)
            stk_pkg::MODE_COMMENT: begin
                if (ch == stk_pkg::CH_NUL || ch == stk_pkg::CH_NL)
                    scan_state = stk_pkg::MODE_IDLE;
            end
            stk_pkg::MODE_SLASH: begin
                if (ch == stk_pkg::CH_SLASH) begin
                    scan_state = stk_pkg::MODE_COMMENT;
                end else begin
                    // The held slash becomes the first character of a word.
                    kept_chars    = 0;
                    chars_dropped = 1'b0;
                    scan_state    = stk_pkg::MODE_WORD;
                    keep_token_char(stk_pkg::CH_SLASH, stk_pkg::KIND_WORD);
                    word_char_step(ch);
                end
            end
            stk_pkg::MODE_WORD: word_char_step(ch);
            stk_pkg::MODE_QUOTE: begin
                if (ch == stk_pkg::CH_QUOTE || ch == stk_pkg::CH_NUL)
                    close_open_token(stk_pkg::KIND_STRING);
                else
                    keep_token_char(ch, stk_pkg::KIND_STRING);
            end
            default: begin
                scan_state = stk_pkg::MODE_IDLE;
                if (!is_blank(ch)) begin
                    kept_chars    = 0;
                    chars_dropped = 1'b0;
                    if (ch == stk_pkg::CH_SLASH) begin
                        scan_state = stk_pkg::MODE_SLASH;
                    end else if (ch == stk_pkg::CH_QUOTE) begin
                        scan_state = stk_pkg::MODE_QUOTE;
                    end else if (is_single_char(ch)) begin
                        emit_single_char(ch);
                    end else begin
                        scan_state = stk_pkg::MODE_WORD;
                        keep_token_char(ch, stk_pkg::KIND_WORD);
                    end
                end
            end
        endcase
    endfunction

    // Random characters of each class.
    function automatic logic [7:0] rand_word_char(input bit at_start);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(33, 127));
        end while (is_single_char(c) ||
                   (at_start && (c == stk_pkg::CH_SLASH || c == stk_pkg::CH_QUOTE)));
        return c;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0: return stk_pkg::CH_SPACE;
            1: return 8'($urandom_range(1, 32));
            2: return 8'($urandom_range(128, 255));
            default: return stk_pkg::CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] rand_single_char();
        case ($urandom_range(0, 5))
            0: return stk_pkg::CH_LBRACE;
            1: return stk_pkg::CH_RBRACE;
            2: return stk_pkg::CH_LPAREN;
            3: return stk_pkg::CH_RPAREN;
            4: return stk_pkg::CH_APOS;
            default: return stk_pkg::CH_COLON;
        endcase
    endfunction

    function automatic logic [7:0] rand_string_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == stk_pkg::CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] rand_comment_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == stk_pkg::CH_NL);
        return c;
    endfunction

    // Send one byte request; bursts of random length are separated by random gaps.
    task automatic send_text_byte(input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tdata  <= ch;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_token_results(ch);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Hold off new requests until every predicted result has come out.
    task automatic wait_for_tokens_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (token_results_due.size() != 0);
        burst_left = 0;
    endtask

    // Edge bytes, every delimiter, comments, held slashes, strings and zero bytes.
    task automatic test_corner_bytes();
        logic [7:0] script[$];
        script = '{stk_pkg::CH_NUL, 8'hFF, stk_pkg::CH_QUOTE, stk_pkg::CH_QUOTE,
                   stk_pkg::CH_QUOTE, 8'h41, stk_pkg::CH_NUL,
                   stk_pkg::CH_SLASH, stk_pkg::CH_SLASH, 8'h63, stk_pkg::CH_NL,
                   stk_pkg::CH_SLASH, 8'h78, 8'h80,
                   stk_pkg::CH_SLASH, stk_pkg::CH_LPAREN, stk_pkg::CH_SLASH,
                   stk_pkg::CH_SPACE, 8'h62, stk_pkg::CH_QUOTE, stk_pkg::CH_RBRACE,
                   stk_pkg::CH_RPAREN, stk_pkg::CH_COLON, stk_pkg::CH_APOS,
                   stk_pkg::CH_LBRACE, stk_pkg::CH_SLASH, stk_pkg::CH_SLASH,
                   stk_pkg::CH_NUL, 8'h7F, stk_pkg::CH_NUL};
        foreach (script[i])
            send_text_byte(script[i]);
    endtask

    // Tokens that reach the size limit and lose one character, for words and strings.
    task automatic test_long_tokens();
        send_text_byte(rand_word_char(1'b1));
        repeat (TOKEN_LIMIT - 1) send_text_byte(rand_word_char(1'b0));
        send_text_byte(stk_pkg::CH_LBRACE);
        send_text_byte(stk_pkg::CH_QUOTE);
        repeat (TOKEN_LIMIT) send_text_byte(rand_string_char());
        send_text_byte(stk_pkg::CH_QUOTE);
    endtask

    // Mostly well-formed script pieces with random content, plus raw noise.
    task automatic test_random_script();
        int len;
        bit paused;
        paused = 1'b0;
        while (bytes_sent < ITEM_TARGET) begin
            if (!paused && bytes_sent >= PAUSE_POINT) begin
                wait_for_tokens_drained();
                paused = 1'b1;
            end
            case ($urandom_range(0, 10))
                0, 1, 2: begin
                    len = $urandom_range(0, 7);
                    send_text_byte(rand_word_char(1'b1));
                    repeat (len) send_text_byte(rand_word_char(1'b0));
                    case ($urandom_range(0, 3))
                        0: send_text_byte(rand_blank());
                        1: send_text_byte(rand_single_char());
                        2: send_text_byte(stk_pkg::CH_NUL);
                        default: ;
                    endcase
                end
                3: begin
                    len = $urandom_range(0, 8);
                    send_text_byte(stk_pkg::CH_QUOTE);
                    repeat (len) send_text_byte(rand_string_char());
                    send_text_byte(($urandom_range(0, 4) == 0) ? stk_pkg::CH_NUL
                                                               : stk_pkg::CH_QUOTE);
                end
                4: begin
                    send_text_byte(rand_single_char());
                end
                5: begin
                    repeat ($urandom_range(1, 3)) send_text_byte(rand_blank());
                end
                6: begin
                    send_text_byte(stk_pkg::CH_SLASH);
                    send_text_byte(stk_pkg::CH_SLASH);
                    repeat ($urandom_range(0, 6)) send_text_byte(rand_comment_char());
                    send_text_byte(($urandom_range(0, 3) == 0) ? stk_pkg::CH_NUL
                                                               : stk_pkg::CH_NL);
                end
                7: begin
                    send_text_byte(stk_pkg::CH_SLASH);
                    send_text_byte(8'($urandom));
                end
                8: begin
                    send_text_byte(stk_pkg::CH_NUL);
                end
                default: begin
                    len = $urandom_range(1, 4);
                    repeat (len) send_text_byte(8'($urandom));
                end
            endcase
        end
    endtask

    // The result side stalls on a pattern of its own that changes now and then.
    int ready_style = 0;
    int ready_hold  = 0;
    int ready_phase = 0;
    always @(negedge clk) begin
        if (ready_hold == 0) begin
            ready_style = $urandom_range(0, 3);
            ready_hold  = $urandom_range(32, 200);
        end
        ready_hold--;
        ready_phase = (ready_phase == 2) ? 0 : ready_phase + 1;
        case (ready_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (ready_phase == 0);
            default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk) begin
        stk_pkg::t_result got;
        stk_pkg::t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got.token_byte   = m_tdata[7:0];
            got.token_length = m_tdata[13:8];
            got.truncated    = m_tdata[14];
            got.token_last   = m_tlast;
            got.byte_valid   = m_tuser[0];
            got.token_kind   = stk_pkg::t_kind'(m_tuser[2:1]);
            if (token_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected: byte=%h valid=%b last=%b kind=%0d len=%0d trunc=%b",
                             got.token_byte, got.byte_valid, got.token_last, got.token_kind,
                             got.token_length, got.truncated);
            end else begin
                want = token_results_due.pop_front();
                if (got.token_byte !== want.token_byte || got.byte_valid !== want.byte_valid ||
                    got.token_last !== want.token_last || got.token_kind !== want.token_kind ||
                    got.token_length !== want.token_length ||
                    got.truncated !== want.truncated) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("mismatch: expected byte=%h valid=%b last=%b kind=%0d len=%0d trunc=%b",
                                 want.token_byte, want.byte_valid, want.token_last,
                                 want.token_kind, want.token_length, want.truncated);
                        $display("          got      byte=%h valid=%b last=%b kind=%0d len=%0d trunc=%b",
                                 got.token_byte, got.byte_valid, got.token_last,
                                 got.token_kind, got.token_length, got.truncated);
                    end
                end
            end
        end
    end

    // Stop a run in which neither side moves a request for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Reset, then the tests in turn, then the final verdict.
    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_corner_bytes();
        wait_for_tokens_drained();
        test_long_tokens();
        wait_for_tokens_drained();
        test_random_script();
        wait_for_tokens_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && token_results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- script_tokenizer_core.f -----
+incdir+rtl/core
rtl/core/stk_pkg.sv
rtl/core/stk_scan.sv
rtl/core/stk_res_queue.sv
rtl/core/script_tokenizer_core.sv
bench/testbench.sv
